[rtl/csp_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the capture stream section parser
// no dependencies

package csp_pkg;

  localparam int MAX_SECTIONS_DEF = 8;
  localparam int HDR_LEN = 68;
  localparam int SEC_HDR_LEN = 12;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SIZE = 2'd1;
  localparam logic [1:0] ST_HEADER = 2'd2;

  localparam logic CFG_MAGIC = 1'b0;
  localparam logic CFG_VERSION = 1'b1;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_SECHDR = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]  sec_type;
    logic [7:0]  sec_version;
    logic [15:0] record_size;
    logic [31:0] record_total;
    logic [31:0] payload_size;
    logic [31:0] payload_start;
  } entry_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        sec_done;
    logic [63:0] device;
    logic [31:0] capture;
  } pstat_t;

endpackage

[rtl/csp_table.sv]
`timescale 1ns / 1ps
// section table memory, one write and one registered read port
// depends on csp_pkg

module csp_table #(
  parameter int MAX_SECTIONS = csp_pkg::MAX_SECTIONS_DEF,
  parameter int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  csp_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output csp_pkg::entry_t rdata
);

  csp_pkg::entry_t mem [MAX_SECTIONS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/csp_parser.sv]
`timescale 1ns / 1ps
// byte walk over header and section headers, verdict and table writes
// depends on csp_pkg

module csp_parser #(
  parameter int MAX_SECTIONS = csp_pkg::MAX_SECTIONS_DEF,
  parameter int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
  parameter int CW = $clog2(MAX_SECTIONS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             fin,
  input  logic             last,
  input  logic             fin_last,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  input  logic [31:0]      buffer_length,
  input  logic [31:0]      expected_magic,
  input  logic [7:0]       expected_version,
  output csp_pkg::pstat_t  stat,
  output logic [CW-1:0]    stored,
  output logic             tbl_we,
  output logic [AW-1:0]    tbl_waddr,
  output csp_pkg::entry_t  tbl_wdata
);

  typedef struct packed {
    csp_pkg::phase_t phase;
    logic            fail;
  } arr_t;

  function automatic arr_t arrive(input logic [32:0] nss, input logic [31:0] len,
                                  input logic [33:0] qp1);
    arr_t r;
    r.fail = 1'b0;
    r.phase = csp_pkg::PH_IDLE;
    if (nss >= {1'b0, len}) begin
      r.phase = csp_pkg::PH_IDLE;
    end else if (({1'b0, len} - nss) < 33'(csp_pkg::SEC_HDR_LEN)) begin
      r.fail = 1'b1;
    end else if ({1'b0, nss} == qp1) begin
      r.phase = csp_pkg::PH_SECHDR;
    end else begin
      r.phase = csp_pkg::PH_SKIP;
    end
    return r;
  endfunction

  logic [31:0] pos, pos_next;
  logic [31:0] sl, sl_next;
  logic [63:0] acc, acc_next;
  logic [31:0] magic, magic_next;
  logic [7:0]  version, version_next;
  logic [15:0] hlen, hlen_next;
  logic [63:0] device, device_next;
  logic [31:0] capture, capture_next;
  logic [31:0] total, total_next;
  logic [32:0] nss, nss_next;
  logic [11:0][7:0] shb, shb_next;
  csp_pkg::phase_t phase, phase_next;
  logic [1:0]  verdict, verdict_next;
  logic [CW-1:0] stored_next;

  arr_t ar;
  logic [33:0] k;
  logic [33:0] end_s;
  logic [47:0] prod;
  csp_pkg::entry_t ent;
  logic sec_done;

  always_comb begin
    pos_next = pos;
    sl_next = sl;
    acc_next = acc;
    magic_next = magic;
    version_next = version;
    hlen_next = hlen;
    device_next = device;
    capture_next = capture;
    total_next = total;
    nss_next = nss;
    shb_next = shb;
    phase_next = phase;
    verdict_next = verdict;
    stored_next = stored;
    sec_done = 1'b0;
    tbl_we = 1'b0;
    ar = '0;
    k = '0;
    ent.sec_type = shb[0];
    ent.sec_version = shb[1];
    ent.record_size = {shb[3], shb[2]};
    ent.record_total = {shb[7], shb[6], shb[5], shb[4]};
    ent.payload_size = {shb[11], shb[10], shb[9], shb[8]};
    ent.payload_start = 32'({1'b0, nss} + 34'(csp_pkg::SEC_HDR_LEN));
    end_s = {1'b0, nss} + 34'(csp_pkg::SEC_HDR_LEN) + {2'b0, ent.payload_size};
    prod = ent.record_size * ent.record_total;

    if (step) begin
      if (first_byte) begin
        pos_next = '0;
        sl_next = buffer_length;
        acc_next = '0;
        magic_next = '0;
        version_next = '0;
        hlen_next = '0;
        device_next = '0;
        capture_next = '0;
        total_next = '0;
        nss_next = '0;
        shb_next = '0;
        verdict_next = csp_pkg::ST_OK;
        stored_next = '0;
        phase_next = csp_pkg::PH_HEADER;
        if (buffer_length < 32'(csp_pkg::HDR_LEN)) begin
          verdict_next = csp_pkg::ST_SIZE;
          phase_next = csp_pkg::PH_IDLE;
        end
      end
      if (pos_next < sl_next) begin
        case (phase_next)
          csp_pkg::PH_HEADER: begin
            acc_next = {data_byte, acc_next[63:8]};
            if (pos_next == 32'd3) magic_next = acc_next[63:32];
            if (pos_next == 32'd4) version_next = acc_next[63:56];
            if (pos_next == 32'd7) hlen_next = acc_next[63:48];
            if (pos_next == 32'd15) device_next = acc_next;
            if (pos_next == 32'd19) capture_next = acc_next[63:32];
            if (pos_next == 32'd39) total_next = acc_next[63:32];
            if (pos_next == 32'(csp_pkg::HDR_LEN - 1)) begin
              if (magic_next != expected_magic || version_next != expected_version ||
                  hlen_next < 16'(csp_pkg::HDR_LEN) || total_next != sl_next) begin
                if (verdict_next == csp_pkg::ST_OK) verdict_next = csp_pkg::ST_HEADER;
                phase_next = csp_pkg::PH_IDLE;
              end else begin
                nss_next = {17'b0, hlen_next};
                ar = arrive(nss_next, sl_next, {2'b0, pos_next} + 34'd1);
                if (ar.fail) begin
                  if (verdict_next == csp_pkg::ST_OK) verdict_next = csp_pkg::ST_SIZE;
                  phase_next = csp_pkg::PH_IDLE;
                end else begin
                  phase_next = ar.phase;
                end
              end
            end
          end
          csp_pkg::PH_SKIP: begin
            if ({2'b0, pos_next} + 34'd1 == {1'b0, nss_next}) phase_next = csp_pkg::PH_SECHDR;
          end
          csp_pkg::PH_SECHDR: begin
            k = {2'b0, pos_next} - {1'b0, nss_next};
            if (k >= 34'(csp_pkg::SEC_HDR_LEN)) begin
              if (verdict_next == csp_pkg::ST_OK) verdict_next = csp_pkg::ST_SIZE;
              phase_next = csp_pkg::PH_IDLE;
            end else begin
              shb_next[k[3:0]] = data_byte;
              if (k == 34'(csp_pkg::SEC_HDR_LEN - 1)) sec_done = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (pos_next != '1) pos_next = pos_next + 32'd1;
      if (last && !sec_done && pos_next != sl_next && verdict_next == csp_pkg::ST_OK) begin
        verdict_next = csp_pkg::ST_SIZE;
        phase_next = csp_pkg::PH_IDLE;
      end
    end

    if (fin) begin
      if (prod != {16'b0, ent.payload_size} || end_s > {2'b0, sl}) begin
        if (verdict_next == csp_pkg::ST_OK) verdict_next = csp_pkg::ST_SIZE;
        phase_next = csp_pkg::PH_IDLE;
      end else begin
        if (32'(stored) < 32'(MAX_SECTIONS)) begin
          tbl_we = 1'b1;
          stored_next = stored + CW'(1);
        end
        nss_next = end_s[32:0];
        ar = arrive(nss_next, sl, {1'b0, nss} + 34'(csp_pkg::SEC_HDR_LEN));
        if (ar.fail) begin
          if (verdict_next == csp_pkg::ST_OK) verdict_next = csp_pkg::ST_SIZE;
          phase_next = csp_pkg::PH_IDLE;
        end else begin
          phase_next = ar.phase;
        end
      end
      if (fin_last && pos != sl && verdict_next == csp_pkg::ST_OK) begin
        verdict_next = csp_pkg::ST_SIZE;
        phase_next = csp_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sl <= '0;
      acc <= '0;
      magic <= '0;
      version <= '0;
      hlen <= '0;
      device <= '0;
      capture <= '0;
      total <= '0;
      nss <= '0;
      shb <= '0;
      phase <= csp_pkg::PH_HEADER;
      verdict <= csp_pkg::ST_OK;
      stored <= '0;
    end else begin
      pos <= pos_next;
      sl <= sl_next;
      acc <= acc_next;
      magic <= magic_next;
      version <= version_next;
      hlen <= hlen_next;
      device <= device_next;
      capture <= capture_next;
      total <= total_next;
      nss <= nss_next;
      shb <= shb_next;
      phase <= phase_next;
      verdict <= verdict_next;
      stored <= stored_next;
    end
  end

  assign tbl_waddr = AW'(stored);
  assign tbl_wdata = ent;
  assign stat.verdict = verdict;
  assign stat.sec_done = sec_done;
  assign stat.device = device;
  assign stat.capture = capture;

endmodule

[rtl/capture_stream_section_parser_core.sv]
`timescale 1ns / 1ps
// top level of the capture stream section parser: handshake, control, result register
// depends on csp_pkg, csp_parser, csp_table
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    mode, data_byte, first_byte, last_byte,
//                                           buffer_length, query_type
// out       output     out_valid/out_ready  result_kind ... capture_ident
// cfg       input      cfg_we               cfg_index, cfg_data
//
// a stream byte that ends a section header also passes through S_FIN (mult and length check)
// a last byte passes through S_EMIT to build the status result
// a lookup reads the section table one entry per cycle, up to the first match or the last stored entry
// in_ready is low while an item is at work or a result waits in the output register
// reset is synchronous; the section table needs no clearing

module capture_stream_section_parser_core #(
  parameter int MAX_SECTIONS = csp_pkg::MAX_SECTIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [31:0] buffer_length,
  input  logic [7:0]  query_type,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [1:0]  status,
  output logic [3:0]  table_count,
  output logic        found,
  output logic [7:0]  sec_type,
  output logic [7:0]  sec_version,
  output logic [15:0] sec_record_size,
  output logic [31:0] sec_record_total,
  output logic [31:0] sec_payload_size,
  output logic [31:0] sec_payload_start,
  output logic [63:0] device_ident,
  output logic [31:0] capture_ident,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CW = $clog2(MAX_SECTIONS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIN  = 4'b0010,
    S_LOOK = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [31:0] exp_magic;
  logic [7:0]  exp_version;
  logic        pend_last, pend_last_next;
  logic [AW-1:0] look_idx, look_idx_next;
  logic [7:0]  query, query_next;

  logic accept, step, fin, re, load, load_kind, load_found, match;
  logic [AW-1:0] raddr;
  csp_pkg::pstat_t stat;
  logic [CW-1:0] stored;
  logic tbl_we;
  logic [AW-1:0] tbl_waddr;
  csp_pkg::entry_t tbl_wdata, rdata, load_entry, out_entry;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept = in_valid && in_ready;
  assign match = (rdata.sec_type == query);

  csp_parser #(.MAX_SECTIONS(MAX_SECTIONS), .AW(AW), .CW(CW)) u_parser (
    .clk(clk), .rst(rst), .step(step), .fin(fin), .last(last_byte), .fin_last(pend_last),
    .data_byte(data_byte), .first_byte(first_byte), .buffer_length(buffer_length),
    .expected_magic(exp_magic), .expected_version(exp_version),
    .stat(stat), .stored(stored),
    .tbl_we(tbl_we), .tbl_waddr(tbl_waddr), .tbl_wdata(tbl_wdata)
  );

  csp_table #(.MAX_SECTIONS(MAX_SECTIONS), .AW(AW)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    pend_last_next = pend_last;
    look_idx_next = look_idx;
    query_next = query;
    step = 1'b0;
    fin = 1'b0;
    re = 1'b0;
    raddr = '0;
    load = 1'b0;
    load_kind = 1'b0;
    load_found = 1'b0;
    load_entry = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode) begin
            if (stored == '0) begin
              load = 1'b1;
              load_kind = 1'b1;
            end else begin
              re = 1'b1;
              look_idx_next = '0;
              query_next = query_type;
              state_next = S_LOOK;
            end
          end else begin
            step = 1'b1;
            pend_last_next = last_byte;
            if (stat.sec_done) begin
              state_next = S_FIN;
            end else if (last_byte) begin
              state_next = S_EMIT;
            end
          end
        end
      end
      S_FIN: begin
        fin = 1'b1;
        state_next = pend_last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        load = 1'b1;
        state_next = S_IDLE;
      end
      S_LOOK: begin
        if (match || (CW'(look_idx) + CW'(1)) >= stored) begin
          load = 1'b1;
          load_kind = 1'b1;
          load_found = match;
          load_entry = match ? rdata : '0;
          state_next = S_IDLE;
        end else begin
          re = 1'b1;
          raddr = look_idx + AW'(1);
          look_idx_next = look_idx + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend_last <= 1'b0;
      look_idx <= '0;
      query <= '0;
      exp_magic <= '0;
      exp_version <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend_last <= pend_last_next;
      look_idx <= look_idx_next;
      query <= query_next;
      if (cfg_we) begin
        case (cfg_index)
          csp_pkg::CFG_MAGIC: exp_magic <= cfg_data;
          csp_pkg::CFG_VERSION: exp_version <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind <= load_kind;
      status <= stat.verdict;
      table_count <= 4'(stored);
      found <= load_found;
      out_entry <= load_entry;
      device_ident <= stat.device;
      capture_ident <= stat.capture;
    end
  end

  assign sec_type = out_entry.sec_type;
  assign sec_version = out_entry.sec_version;
  assign sec_record_size = out_entry.record_size;
  assign sec_record_total = out_entry.record_total;
  assign sec_payload_size = out_entry.payload_size;
  assign sec_payload_start = out_entry.payload_start;

  a_fin_next: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |=> state == S_IDLE || state == S_EMIT)
    else $error("section finish did not return to idle or emit");

  a_busy_empty: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !out_valid)
    else $error("result register busy while a transaction is at work");

  a_write_fin: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> state == S_FIN)
    else $error("table write outside section finish");

  a_found_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> result_kind)
    else $error("found set on a status result");

endmodule

[bench/tb_capture_stream_section_parser_core.sv]
`timescale 1ns / 1ps
// self-checking testbench of capture_stream_section_parser_core: random capture buffers
// with lookups in between, predicted by a scoreboard class; depends on csp_pkg and the rtl

module tb_capture_stream_section_parser_core;

  localparam int IDLE_LIMIT = 2000;
  localparam int TABLE_DEPTH = csp_pkg::MAX_SECTIONS_DEF;

  typedef struct {
    logic        kind;
    logic [1:0]  status;
    logic [3:0]  count;
    logic        found;
    logic [7:0]  stype;
    logic [7:0]  sver;
    logic [15:0] rec_size;
    logic [31:0] rec_total;
    logic [31:0] pay_size;
    logic [31:0] pay_start;
    logic [63:0] device;
    logic [31:0] capture;
  } result_t;

  class section_scoreboard;
    bit [31:0] exp_magic;
    bit [7:0] exp_version;
    bit [31:0] pos, buf_len, hdr_magic, hdr_cap, hdr_total;
    bit [63:0] acc, hdr_dev;
    bit [7:0] hdr_ver;
    bit [15:0] hdr_len;
    longint unsigned sec_start;
    bit [7:0] sec_bytes[12];
    csp_pkg::phase_t walk;
    logic [1:0] verdict;
    csp_pkg::entry_t sections[TABLE_DEPTH];
    int stored;
    result_t pending[$];
    int errors;

    function new();
      exp_magic = '0;
      exp_version = '0;
      restart(32'd0);
      errors = 0;
    endfunction

    function void restart(bit [31:0] len);
      pos = '0;
      buf_len = len;
      acc = '0;
      hdr_magic = '0;
      hdr_ver = '0;
      hdr_len = '0;
      hdr_dev = '0;
      hdr_cap = '0;
      hdr_total = '0;
      sec_start = 0;
      foreach (sec_bytes[i]) sec_bytes[i] = '0;
      verdict = csp_pkg::ST_OK;
      stored = 0;
      walk = csp_pkg::PH_HEADER;
    endfunction

    function void latch_error(logic [1:0] code);
      if (verdict == csp_pkg::ST_OK) verdict = code;
      walk = csp_pkg::PH_IDLE;
    endfunction

    function void section_due(bit [31:0] q);
      longint unsigned len;
      len = buf_len;
      if (sec_start >= len) walk = csp_pkg::PH_IDLE;
      else if (len - sec_start < csp_pkg::SEC_HDR_LEN) latch_error(csp_pkg::ST_SIZE);
      else if (sec_start == longint'(q) + 1) walk = csp_pkg::PH_SECHDR;
      else walk = csp_pkg::PH_SKIP;
    endfunction

    function void header_byte(bit [31:0] q, bit [7:0] b);
      acc = {b, acc[63:8]};
      case (q)
        3: hdr_magic = acc[63:32];
        4: hdr_ver = acc[63:56];
        7: hdr_len = acc[63:48];
        15: hdr_dev = acc;
        19: hdr_cap = acc[63:32];
        39: hdr_total = acc[63:32];
        default: ;
      endcase
      if (q == csp_pkg::HDR_LEN - 1) begin
        if (hdr_magic != exp_magic || hdr_ver != exp_version ||
            hdr_len < csp_pkg::HDR_LEN || hdr_total != buf_len) begin
          latch_error(csp_pkg::ST_HEADER);
          return;
        end
        sec_start = hdr_len;
        section_due(q);
      end
    endfunction

    function void section_byte(bit [31:0] q, bit [7:0] b);
      longint unsigned k, fin;
      csp_pkg::entry_t e;
      k = longint'(q) - sec_start;
      if (k >= csp_pkg::SEC_HDR_LEN) begin
        latch_error(csp_pkg::ST_SIZE);
        return;
      end
      sec_bytes[k] = b;
      if (k != csp_pkg::SEC_HDR_LEN - 1) return;
      e.sec_type = sec_bytes[0];
      e.sec_version = sec_bytes[1];
      e.record_size = {sec_bytes[3], sec_bytes[2]};
      e.record_total = {sec_bytes[7], sec_bytes[6], sec_bytes[5], sec_bytes[4]};
      e.payload_size = {sec_bytes[11], sec_bytes[10], sec_bytes[9], sec_bytes[8]};
      e.payload_start = 32'(sec_start + csp_pkg::SEC_HDR_LEN);
      fin = sec_start + csp_pkg::SEC_HDR_LEN + longint'(e.payload_size);
      if (longint'(e.record_size) * longint'(e.record_total) != longint'(e.payload_size) ||
          fin > longint'(buf_len)) begin
        latch_error(csp_pkg::ST_SIZE);
        return;
      end
      if (stored < TABLE_DEPTH) begin
        sections[stored] = e;
        stored++;
      end
      sec_start = fin;
      section_due(q);
    endfunction

    function result_t status_view(bit kind);
      result_t r;
      r = '{default: '0};
      r.kind = kind;
      r.status = verdict;
      r.count = 4'(stored);
      r.device = hdr_dev;
      r.capture = hdr_cap;
      return r;
    endfunction

    function void note_transaction(bit m, bit [7:0] d, bit f, bit l, bit [31:0] bl,
                                   bit [7:0] qt);
      result_t r;
      bit [31:0] q;
      if (m) begin
        r = status_view(1'b1);
        for (int i = 0; i < stored; i++) begin
          if (sections[i].sec_type == qt) begin
            r.found = 1'b1;
            r.stype = sections[i].sec_type;
            r.sver = sections[i].sec_version;
            r.rec_size = sections[i].record_size;
            r.rec_total = sections[i].record_total;
            r.pay_size = sections[i].payload_size;
            r.pay_start = sections[i].payload_start;
            break;
          end
        end
        pending.push_back(r);
        return;
      end
      if (f) begin
        restart(bl);
        if (bl < csp_pkg::HDR_LEN) latch_error(csp_pkg::ST_SIZE);
      end
      q = pos;
      if (q < buf_len) begin
        if (walk == csp_pkg::PH_HEADER) header_byte(q, d);
        else if (walk == csp_pkg::PH_SKIP) begin
          if (longint'(q) + 1 == sec_start) walk = csp_pkg::PH_SECHDR;
        end else if (walk == csp_pkg::PH_SECHDR) section_byte(q, d);
      end
      if (pos != 32'hFFFF_FFFF) pos++;
      if (l) begin
        if (pos != buf_len && verdict == csp_pkg::ST_OK) latch_error(csp_pkg::ST_SIZE);
        pending.push_back(status_view(1'b0));
      end
    endfunction

    task report(string msg);
      $display("error at %0t: %s", $time, msg);
      errors++;
    endtask

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("result with no transaction waiting for it");
        return;
      end
      want = pending.pop_front();
      cmp("result_kind", got.kind, want.kind);
      cmp("status", got.status, want.status);
      cmp("table_count", got.count, want.count);
      cmp("found", got.found, want.found);
      cmp("sec_type", got.stype, want.stype);
      cmp("sec_version", got.sver, want.sver);
      cmp("sec_record_size", got.rec_size, want.rec_size);
      cmp("sec_record_total", got.rec_total, want.rec_total);
      cmp("sec_payload_size", got.pay_size, want.pay_size);
      cmp("sec_payload_start", got.pay_start, want.pay_start);
      cmp("device_ident", got.device, want.device);
      cmp("capture_ident", got.capture, want.capture);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic [7:0] data_byte = '0;
  logic first_byte = 1'b0;
  logic last_byte = 1'b0;
  logic [31:0] buffer_length = 32'd1;
  logic [7:0] query_type = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic result_kind;
  logic [1:0] status;
  logic [3:0] table_count;
  logic found;
  logic [7:0] sec_type, sec_version;
  logic [15:0] sec_record_size;
  logic [31:0] sec_record_total, sec_payload_size, sec_payload_start;
  logic [63:0] device_ident;
  logic [31:0] capture_ident;
  logic cfg_we = 1'b0;
  logic cfg_index = csp_pkg::CFG_MAGIC;
  logic [31:0] cfg_data = '0;

  capture_stream_section_parser_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .data_byte(data_byte), .first_byte(first_byte), .last_byte(last_byte),
    .buffer_length(buffer_length), .query_type(query_type),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .status(status), .table_count(table_count),
    .found(found), .sec_type(sec_type), .sec_version(sec_version),
    .sec_record_size(sec_record_size), .sec_record_total(sec_record_total),
    .sec_payload_size(sec_payload_size), .sec_payload_start(sec_payload_start),
    .device_ident(device_ident), .capture_ident(capture_ident),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  section_scoreboard sb = new();
  int items = 0;
  int results = 0;
  int buffers = 0;
  int lookups = 0;
  int idle_cycles = 0;
  int out_stall = 0;
  bit burst = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // result side: check each result, then a random stall
  always @(posedge clk) begin
    result_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{result_kind, status, table_count, found, sec_type, sec_version,
                sec_record_size, sec_record_total, sec_payload_size, sec_payload_start,
                device_ident, capture_ident};
        sb.check_result(got);
        results++;
        out_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("capture_stream_section_parser_core: mismatch");
        $finish;
      end
    end
  end

  task automatic send(bit m, bit [7:0] d, bit f, bit l, bit [31:0] bl, bit [7:0] qt);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    data_byte <= d;
    first_byte <= f;
    last_byte <= l;
    buffer_length <= bl;
    query_type <= qt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_transaction(m, d, f, l, bl, qt);
    items++;
  endtask

  task automatic lookup(bit [7:0] qt);
    send(1'b1, 8'($urandom), 1'($urandom), 1'($urandom), $urandom, qt);
    lookups++;
  endtask

  task automatic write_regs(bit [31:0] magic, bit [7:0] ver);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= csp_pkg::CFG_MAGIC;
    cfg_data <= magic;
    @(posedge clk);
    cfg_index <= csp_pkg::CFG_VERSION;
    cfg_data <= {24'($urandom), ver};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.exp_magic = magic;
    sb.exp_version = ver;
  endtask

  task automatic run_buffer(bit clean);
    bit [7:0] bytes[$];
    int hlen, nsec, rs, rt, ps, flaw, nsend, at;
    bit [31:0] blen, psz;
    hlen = ($urandom_range(0, 3) == 0) ? csp_pkg::HDR_LEN + $urandom_range(1, 10)
                                       : csp_pkg::HDR_LEN;
    for (int i = 0; i < hlen; i++) bytes.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) bytes[i] = sb.exp_magic[8*i +: 8];
    bytes[4] = sb.exp_version;
    bytes[6] = hlen[7:0];
    bytes[7] = hlen[15:8];
    nsec = $urandom_range(0, 11);
    for (int s = 0; s < nsec; s++) begin
      rs = $urandom_range(0, 5);
      rt = $urandom_range(0, 5);
      ps = rs * rt;
      psz = (!clean && $urandom_range(0, 15) == 0) ? $urandom : 32'(ps);
      bytes.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
      bytes.push_back(8'($urandom));
      bytes.push_back(rs[7:0]);
      bytes.push_back(8'h00);
      for (int i = 0; i < 4; i++) bytes.push_back(rt[8*i +: 8]);
      for (int i = 0; i < 4; i++) bytes.push_back(psz[8*i +: 8]);
      for (int i = 0; i < ps; i++) bytes.push_back(8'($urandom));
    end
    blen = bytes.size();
    nsend = bytes.size();
    flaw = clean ? 0 : $urandom_range(0, 11);
    case (flaw)
      6: begin
        at = $urandom_range(0, bytes.size() - 1);
        bytes[at] = bytes[at] ^ (8'h01 << $urandom_range(0, 7));
      end
      7: blen = ($urandom_range(0, 1) == 0) ? $urandom : blen + $urandom_range(1, 20);
      8: begin
        blen = blen - $urandom_range(1, 20);
        nsend = blen;
      end
      9: nsend = $urandom_range(1, bytes.size());
      10: nsend = bytes.size() + $urandom_range(1, 10);
      11: if ($urandom_range(0, 1) == 0) begin
        bytes[6] = 8'($urandom_range(0, csp_pkg::HDR_LEN - 1));
        bytes[7] = 8'h00;
      end else begin
        bytes[$urandom_range(0, 4)] ^= 8'h10;
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) bytes[36 + i] = blen[8*i +: 8];
    if (flaw == 7 && $urandom_range(0, 1) == 0) bytes[36] ^= 8'h01;
    while (bytes.size() < nsend) bytes.push_back(8'($urandom));
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < nsend; i++) begin
      if ($urandom_range(0, 11) == 0)
        lookup(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
      send(1'b0, bytes[i], i == 0, i == nsend - 1, (i == 0) ? blen : $urandom, 8'($urandom));
    end
    for (int t = 0; t < 4; t++) lookup(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(t));
    buffers++;
  endtask

  initial begin
    bit [31:0] magics[5];
    bit [7:0] versions[5];
    magics = '{32'h0, $urandom, 32'hFFFF_FFFF, 32'h0, $urandom};
    versions = '{8'h0, 8'($urandom), 8'hFF, 8'h0, 8'($urandom)};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray bytes before any buffer start, short and oversized lengths, empty lookups
    send(1'b0, 8'h00, 1'b0, 1'b0, 32'h0000_0001, 8'h00);
    send(1'b0, 8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'hFF);
    lookup(8'h00);
    send(1'b0, 8'hA5, 1'b1, 1'b1, 32'd1, 8'h00);
    send(1'b0, 8'h5A, 1'b1, 1'b1, 32'd67, 8'h00);
    send(1'b0, 8'h00, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'h00);
    lookup(8'hFF);
    run_buffer(1'b1);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_regs(magics[ph], versions[ph]);
      run_buffer(1'b1);
      while (items < (ph + 1) * 240) run_buffer(1'b0);
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("ran %0d buffers and %0d lookups, %0d transactions in, %0d results checked",
             buffers, lookups, items, results);
    $display("five register settings, clean and damaged buffers, random stalls both sides");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("capture_stream_section_parser_core: match");
    end else begin
      $display("capture_stream_section_parser_core: mismatch");
    end
    $finish;
  end

endmodule
